// File: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define NNC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define NNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/nnc_pkg.sv
package nnc_pkg;

  localparam int LANES          = 4;
  localparam int PIXEL_FIELDS   = 4;
  localparam int USED_LANES     = (LANES < PIXEL_FIELDS) ? LANES : PIXEL_FIELDS;
  localparam int TRAIN_CAPACITY = 65536;

  localparam int PIX_W   = 8;
  localparam int SQ_W    = 2 * PIX_W;
  localparam int SUM_W   = SQ_W + $clog2(USED_LANES) + 1;
  localparam int DIST_W  = 26;
  localparam int IDX_W   = 16;
  localparam int CLASS_W = 4;

  localparam logic [DIST_W-1:0] DIST_ONES  = '1;
  localparam logic [IDX_W-1:0]  MATCH_MAX  = '1;
  localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(TRAIN_CAPACITY - 1);

  typedef logic [SQ_W-1:0] sq_arr_t [USED_LANES];

  typedef struct packed {
    logic [CLASS_W-1:0] train_class;
    logic [CLASS_W-1:0] test_class;
    logic               image_end;
    logic               set_end;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]   nearest_index;
    logic [DIST_W-1:0]  nearest_distance;
    logic [CLASS_W-1:0] predicted_class;
    logic               is_match;
    logic [IDX_W-1:0]   match_total;
  } res_t;

endpackage

// File: hdl/nnc_if.sv
interface nnc_in_if;
  logic                         valid;
  logic                         ready;
  logic [nnc_pkg::PIX_W-1:0]    test_pixel_0;
  logic [nnc_pkg::PIX_W-1:0]    test_pixel_1;
  logic [nnc_pkg::PIX_W-1:0]    test_pixel_2;
  logic [nnc_pkg::PIX_W-1:0]    test_pixel_3;
  logic [nnc_pkg::PIX_W-1:0]    train_pixel_0;
  logic [nnc_pkg::PIX_W-1:0]    train_pixel_1;
  logic [nnc_pkg::PIX_W-1:0]    train_pixel_2;
  logic [nnc_pkg::PIX_W-1:0]    train_pixel_3;
  logic [nnc_pkg::CLASS_W-1:0]  train_class;
  logic [nnc_pkg::CLASS_W-1:0]  test_class;
  logic                         image_end;
  logic                         set_end;

  modport source (
    output valid, test_pixel_0, test_pixel_1, test_pixel_2, test_pixel_3,
    output train_pixel_0, train_pixel_1, train_pixel_2, train_pixel_3,
    output train_class, test_class, image_end, set_end,
    input  ready
  );
  modport sink (
    input  valid, test_pixel_0, test_pixel_1, test_pixel_2, test_pixel_3,
    input  train_pixel_0, train_pixel_1, train_pixel_2, train_pixel_3,
    input  train_class, test_class, image_end, set_end,
    output ready
  );
endinterface

interface nnc_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnc_pkg::IDX_W-1:0]    nearest_index;
  logic [nnc_pkg::DIST_W-1:0]   nearest_distance;
  logic [nnc_pkg::CLASS_W-1:0]  predicted_class;
  logic                         is_match;
  logic [nnc_pkg::IDX_W-1:0]    match_total;

  modport source (
    output valid, nearest_index, nearest_distance, predicted_class, is_match, match_total,
    input  ready
  );
  modport sink (
    input  valid, nearest_index, nearest_distance, predicted_class, is_match, match_total,
    output ready
  );
endinterface

// File: hdl/nnc_lane.sv
module nnc_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [nnc_pkg::PIX_W-1:0]  test_px,
  input  logic [nnc_pkg::PIX_W-1:0]  train_px,
  output logic [nnc_pkg::SQ_W-1:0]   sq_r
);

  logic [nnc_pkg::PIX_W-1:0] diff;
  logic [nnc_pkg::SQ_W-1:0]  sq_nxt;

  assign diff   = (test_px >= train_px) ? (test_px - train_px) : (train_px - test_px);
  assign sq_nxt = nnc_pkg::SQ_W'(diff) * nnc_pkg::SQ_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

// File: hdl/nnc_merge.sv
`include "assert_macros.svh"

module nnc_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  nnc_pkg::ctl_t     ctl,
  input  nnc_pkg::sq_arr_t  sq,
  input  logic              out_ready,
  output logic              take,
  output nnc_pkg::res_t     res_r,
  output logic              out_valid_r
);

  logic [nnc_pkg::DIST_W-1:0]  running_r, running_nxt;
  logic [nnc_pkg::DIST_W-1:0]  best_d_r, best_d_nxt;
  logic [nnc_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [nnc_pkg::CLASS_W-1:0] best_class_r, best_class_nxt;
  logic [nnc_pkg::IDX_W-1:0]   img_cnt_r, img_cnt_nxt;
  logic [nnc_pkg::IDX_W-1:0]   match_r, match_nxt;
  logic                        out_valid_nxt;
  nnc_pkg::res_t               res_nxt;

  logic [nnc_pkg::SUM_W-1:0]   sum;
  logic [nnc_pkg::DIST_W:0]    total_wide;
  logic [nnc_pkg::DIST_W-1:0]  total;
  logic                        better;
  logic                        is_match;

  // Hold a set-ending item while the previous result is still waiting.
  assign take = s1_valid && !(ctl.set_end && out_valid_r && !out_ready);

  always_comb begin
    sum = '0;
    for (int i = 0; i < nnc_pkg::USED_LANES; i++) begin
      sum = sum + nnc_pkg::SUM_W'(sq[i]);
    end
  end

  assign total_wide = {1'b0, running_r} + (nnc_pkg::DIST_W + 1)'(sum);
  assign total      = total_wide[nnc_pkg::DIST_W] ? nnc_pkg::DIST_ONES
                                                  : total_wide[nnc_pkg::DIST_W-1:0];
  assign better     = total < best_d_r;

  always_comb begin
    running_nxt    = running_r;
    best_d_nxt     = best_d_r;
    best_idx_nxt   = best_idx_r;
    best_class_nxt = best_class_r;
    img_cnt_nxt    = img_cnt_r;
    match_nxt      = match_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    res_nxt        = res_r;
    is_match       = 1'b0;
    if (take) begin
      if (!ctl.image_end) begin
        running_nxt = total;
      end else begin
        running_nxt = '0;
        if (better) begin
          best_d_nxt     = total;
          best_idx_nxt   = img_cnt_r;
          best_class_nxt = ctl.train_class;
        end
        if (img_cnt_r != nnc_pkg::LAST_INDEX) begin
          img_cnt_nxt = img_cnt_r + 1'b1;
        end
        if (ctl.set_end) begin
          is_match = (best_class_nxt == ctl.test_class);
          if (is_match && match_r != nnc_pkg::MATCH_MAX) begin
            match_nxt = match_r + 1'b1;
          end
          res_nxt.nearest_index    = best_idx_nxt;
          res_nxt.nearest_distance = best_d_nxt;
          res_nxt.predicted_class  = best_class_nxt;
          res_nxt.is_match         = is_match;
          res_nxt.match_total      = match_nxt;
          out_valid_nxt            = 1'b1;
          best_d_nxt               = nnc_pkg::DIST_ONES;
          best_idx_nxt             = '0;
          best_class_nxt           = '0;
          img_cnt_nxt              = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= '0;
      best_d_r     <= nnc_pkg::DIST_ONES;
      best_idx_r   <= '0;
      best_class_r <= '0;
      img_cnt_r    <= '0;
      match_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      running_r    <= running_nxt;
      best_d_r     <= best_d_nxt;
      best_idx_r   <= best_idx_nxt;
      best_class_r <= best_class_nxt;
      img_cnt_r    <= img_cnt_nxt;
      match_r      <= match_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `NNC_ASSERT(a_reset_best_empty, (best_d_r != nnc_pkg::DIST_ONES) || (best_idx_r == '0 && best_class_r == '0), "best index or class set without a closer image")
  `NNC_ASSERT_NEXT(a_image_end_clears, take && ctl.image_end, running_r == '0, "running distance not cleared at image end")
  `NNC_ASSERT_NEXT(a_match_monotonic, 1'b1, match_r >= $past(match_r), "match count decreased")
  `NNC_ASSERT_NEXT(a_set_end_clears, take && ctl.set_end, img_cnt_r == '0 && out_valid_r, "search state not cleared or result lost at set end")

endmodule

// File: hdl/nearest_neighbour_classifier.sv
// One-nearest-neighbour classifier, squared Euclidean distance.
// in_ch: each item carries four test pixels and the matching training pixels
//   of one training image, the image's label, the test label and the
//   image_end / set_end markers. set_end also closes the current image.
// out_ch: one result per set: index, distance and label of the first image
//   at minimum distance, a match flag and a saturating count of matches.
// Throughput: one item per cycle while no set-ending item is held; four lanes square
//   pixel differences in parallel and a merge stage accumulates and tracks the minimum.
// Result path: an accepted set-ending item passes the lane register, then the
//   output register, where its result is shown valid.
// Receiver stall: ordinary items keep flowing while a result waits; only a
//   further set-ending item is held until the waiting result is taken.
// Reset: clears the search state and the match count; no result is pending.
module nearest_neighbour_classifier (
  input  logic       clk,
  input  logic       rst_n,
  nnc_in_if.sink     in_ch,
  nnc_out_if.source  out_ch
);

  logic [nnc_pkg::PIX_W-1:0] test_px  [nnc_pkg::PIXEL_FIELDS];
  logic [nnc_pkg::PIX_W-1:0] train_px [nnc_pkg::PIXEL_FIELDS];
  nnc_pkg::sq_arr_t          sq;
  nnc_pkg::ctl_t             s1_ctl_r;
  nnc_pkg::res_t             res;
  logic                      s1_valid_r;
  logic                      take;
  logic                      en_s1;
  logic                      load_s1;
  logic                      out_valid;

  assign test_px[0]  = in_ch.test_pixel_0;
  assign test_px[1]  = in_ch.test_pixel_1;
  assign test_px[2]  = in_ch.test_pixel_2;
  assign test_px[3]  = in_ch.test_pixel_3;
  assign train_px[0] = in_ch.train_pixel_0;
  assign train_px[1] = in_ch.train_pixel_1;
  assign train_px[2] = in_ch.train_pixel_2;
  assign train_px[3] = in_ch.train_pixel_3;

  assign en_s1       = !s1_valid_r || take;
  assign load_s1     = en_s1 && in_ch.valid;
  assign in_ch.ready = en_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en_s1) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_ctl_r.train_class <= in_ch.train_class;
      s1_ctl_r.test_class  <= in_ch.test_class;
      s1_ctl_r.image_end   <= in_ch.image_end || in_ch.set_end;
      s1_ctl_r.set_end     <= in_ch.set_end;
    end
  end

  for (genvar g = 0; g < nnc_pkg::USED_LANES; g++) begin : g_lane
    nnc_lane u_lane (
      .clk      (clk),
      .en       (load_s1),
      .test_px  (test_px[g]),
      .train_px (train_px[g]),
      .sq_r     (sq[g])
    );
  end

  nnc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid_r),
    .ctl         (s1_ctl_r),
    .sq          (sq),
    .out_ready   (out_ch.ready),
    .take        (take),
    .res_r       (res),
    .out_valid_r (out_valid)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.nearest_index    = res.nearest_index;
  assign out_ch.nearest_distance = res.nearest_distance;
  assign out_ch.predicted_class  = res.predicted_class;
  assign out_ch.is_match         = res.is_match;
  assign out_ch.match_total      = res.match_total;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [nnc_pkg::PIXEL_FIELDS-1:0][nnc_pkg::PIX_W-1:0] test_px;
    logic [nnc_pkg::PIXEL_FIELDS-1:0][nnc_pkg::PIX_W-1:0] train_px;
    logic [nnc_pkg::CLASS_W-1:0]                          train_class;
    logic [nnc_pkg::CLASS_W-1:0]                          test_class;
    logic                                                 image_end;
    logic                                                 set_end;
  } pixel_item_t;

  logic clk;
  logic rst_n;

  nnc_in_if  in_ch ();
  nnc_out_if out_ch ();

  nearest_neighbour_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nnc_pkg::res_t               verdict_q[$];
  logic [nnc_pkg::DIST_W-1:0]  run_dist;
  logic [nnc_pkg::DIST_W-1:0]  best_dist;
  logic [nnc_pkg::IDX_W-1:0]   best_idx;
  logic [nnc_pkg::IDX_W-1:0]   image_idx;
  logic [nnc_pkg::IDX_W-1:0]   match_count;
  logic [nnc_pkg::CLASS_W-1:0] best_class;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void restart_search();
    run_dist   = '0;
    best_dist  = nnc_pkg::DIST_ONES;
    best_idx   = '0;
    best_class = '0;
    image_idx  = '0;
  endfunction

  function automatic void classify_pixels(pixel_item_t it);
    int unsigned     lane_sum;
    longint unsigned total;
    int              diff;
    nnc_pkg::res_t   r;
    lane_sum = 0;
    for (int i = 0; i < nnc_pkg::USED_LANES; i++) begin
      diff = int'(it.test_px[i]) - int'(it.train_px[i]);
      lane_sum += diff * diff;
    end
    total = longint'(run_dist) + lane_sum;
    if (total > nnc_pkg::DIST_ONES) total = nnc_pkg::DIST_ONES;
    if (!(it.image_end || it.set_end)) begin
      run_dist = nnc_pkg::DIST_W'(total);
    end else begin
      if (total < best_dist) begin
        best_dist  = nnc_pkg::DIST_W'(total);
        best_idx   = image_idx;
        best_class = it.train_class;
      end
      run_dist = '0;
      if (image_idx < nnc_pkg::LAST_INDEX) image_idx++;
      if (it.set_end) begin
        r.is_match = (best_class == it.test_class);
        if (r.is_match && match_count < nnc_pkg::MATCH_MAX) match_count++;
        r.nearest_index    = best_idx;
        r.nearest_distance = best_dist;
        r.predicted_class  = best_class;
        r.match_total      = match_count;
        verdict_q.push_back(r);
        restart_search();
      end
    end
  endfunction

  function automatic pixel_item_t pixel_item(logic [31:0] test_px, logic [31:0] train_px,
                                             logic [nnc_pkg::CLASS_W-1:0] train_cls,
                                             logic [nnc_pkg::CLASS_W-1:0] test_cls,
                                             logic img_end, logic last);
    pixel_item_t it;
    it.test_px     = test_px;
    it.train_px    = train_px;
    it.train_class = train_cls;
    it.test_class  = test_cls;
    it.image_end   = img_end;
    it.set_end     = last;
    return it;
  endfunction

  function automatic logic [nnc_pkg::CLASS_W-1:0] random_class();
    return ($urandom_range(4) == 0) ? nnc_pkg::CLASS_W'($urandom_range(15))
                                    : nnc_pkg::CLASS_W'($urandom_range(9));
  endfunction

  function automatic logic [31:0] random_lanes(int mode);
    logic [31:0] v;
    v = $urandom;
    for (int i = 0; i < nnc_pkg::PIXEL_FIELDS; i++) begin
      if (mode == 1) v[8*i +: 8] = 8'($urandom_range(3));
      else if (mode == 2 && $urandom_range(1)) v[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return v;
  endfunction

  task automatic send_item(pixel_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.test_pixel_0  <= it.test_px[0];
    in_ch.test_pixel_1  <= it.test_px[1];
    in_ch.test_pixel_2  <= it.test_px[2];
    in_ch.test_pixel_3  <= it.test_px[3];
    in_ch.train_pixel_0 <= it.train_px[0];
    in_ch.train_pixel_1 <= it.train_px[1];
    in_ch.train_pixel_2 <= it.train_px[2];
    in_ch.train_pixel_3 <= it.train_px[3];
    in_ch.train_class   <= it.train_class;
    in_ch.test_class    <= it.test_class;
    in_ch.image_end     <= it.image_end;
    in_ch.set_end       <= it.set_end;
    do @(posedge clk); while (!in_ch.ready);
    classify_pixels(it);
  endtask

  task automatic wait_for_verdicts();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  always @(posedge clk) begin : verdict_check
    nnc_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: index %0d distance %0d class %0d match %0d total %0d",
                   out_ch.nearest_index, out_ch.nearest_distance, out_ch.predicted_class,
                   out_ch.is_match, out_ch.match_total);
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.nearest_index !== want.nearest_index ||
            out_ch.nearest_distance !== want.nearest_distance ||
            out_ch.predicted_class !== want.predicted_class ||
            out_ch.is_match !== want.is_match ||
            out_ch.match_total !== want.match_total) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("bad result: want index %0d distance %0d class %0d match %0d total %0d,%s",
                     want.nearest_index, want.nearest_distance, want.predicted_class,
                     want.is_match, want.match_total,
                     $sformatf(" got %0d %0d %0d %0d %0d", out_ch.nearest_index,
                               out_ch.nearest_distance, out_ch.predicted_class,
                               out_ch.is_match, out_ch.match_total));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(pixel_item(32'h0, 32'h0, 4'd0, 4'd0, 1'b1, 1'b1));
    // one lane at a time, ties keep the earlier image, labels above nine
    send_item(pixel_item(32'h0, 32'h000000FF, 4'd12, 4'd15, 1'b0, 1'b0));
    send_item(pixel_item(32'h00000100, 32'h0, 4'd12, 4'd15, 1'b1, 1'b0));
    send_item(pixel_item(32'h0000FF00, 32'h0, 4'd13, 4'd15, 1'b1, 1'b0));
    send_item(pixel_item(32'h0, 32'h00FF0000, 4'd14, 4'd15, 1'b1, 1'b0));
    send_item(pixel_item(32'hC8000000, 32'hFF000000, 4'd15, 4'd15, 1'b1, 1'b0));
    send_item(pixel_item(32'h0, 32'h37000000, 4'd9, 4'd15, 1'b0, 1'b1));
    wait_for_verdicts();
    send_item(pixel_item(32'hFFFFFFFF, 32'h0, 4'd5, 4'd3, 1'b1, 1'b0));
    send_item(pixel_item(32'hA5A5A5A5, 32'hA5A5A5A5, 4'd10, 4'd3, 1'b1, 1'b0));
    send_item(pixel_item(32'h5A5A5A5A, 32'h5A5A5A5B, 4'd11, 4'd3, 1'b1, 1'b1));
    send_item(pixel_item(32'h12345678, 32'h87654321, 4'd4, 4'd4, 1'b0, 1'b0));
    send_item(pixel_item(32'h00FF00FF, 32'hFF00FF00, 4'd4, 4'd4, 1'b0, 1'b0));
    send_item(pixel_item(32'h7F807F80, 32'h807F807F, 4'd4, 4'd4, 1'b0, 1'b1));
  endtask

  task automatic test_distance_saturation();
    send_idle_pct = 0;
    stall_pct     = 0;
    // 260 full-scale items push one image past the distance ceiling
    for (int n = 0; n < 260; n++)
      send_item(pixel_item(n[0] ? 32'hFFFFFFFF : 32'h0, n[0] ? 32'h0 : 32'hFFFFFFFF,
                           4'd7, 4'd0, 1'b0, n == 259));
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_chance, int item_budget);
    pixel_item_t                 it;
    logic [nnc_pkg::CLASS_W-1:0] truth;
    logic [nnc_pkg::CLASS_W-1:0] label;
    int                          images;
    int                          beats;
    int                          sent;
    int                          mode;
    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    sent          = 0;
    while (sent < item_budget) begin
      if ($urandom_range(9) == 0) wait_for_verdicts();
      images = $urandom_range(1, 5);
      truth  = random_class();
      mode   = $urandom_range(2);
      for (int m = 0; m < images; m++) begin
        beats = $urandom_range(1, 4);
        label = ($urandom_range(2) == 0) ? truth : random_class();
        for (int b = 0; b < beats; b++) begin
          it = pixel_item(random_lanes(mode), random_lanes(mode), label, truth,
                          b == beats - 1, m == images - 1 && b == beats - 1);
          if ($urandom_range(15) == 0) begin
            it.image_end  = 1'($urandom_range(1));
            it.set_end    = 1'($urandom_range(1));
            it.test_class = random_class();
          end
          send_item(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.test_pixel_0  = '0;
    in_ch.test_pixel_1  = '0;
    in_ch.test_pixel_2  = '0;
    in_ch.test_pixel_3  = '0;
    in_ch.train_pixel_0 = '0;
    in_ch.train_pixel_1 = '0;
    in_ch.train_pixel_2 = '0;
    in_ch.train_pixel_3 = '0;
    in_ch.train_class   = '0;
    in_ch.test_class    = '0;
    in_ch.image_end     = 1'b0;
    in_ch.set_end       = 1'b0;
    restart_search();
    match_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_distance_saturation();
    test_random_traffic(0, 0, 95);
    test_random_traffic(66, 0, 95);
    test_random_traffic(0, 66, 95);
    test_random_traffic(21, 21, 95);

    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/nnc_pkg.sv
hdl/nnc_if.sv
hdl/nnc_lane.sv
hdl/nnc_merge.sv
hdl/nearest_neighbour_classifier.sv
test/tb_top.sv
